>>> sv/srld_pkg.sv
// ----------------------------------------------------------------------------
// srld_pkg: shared types and constants of the sprite RLE line decoder
// Result kinds, the record that travels from the front end to the back end,
// and the sizes of the queue between them.
// ----------------------------------------------------------------------------
`default_nettype none

package srld_pkg;

   localparam int WORD_W   = 16;
   localparam int RUN_W    = 15;
   localparam int INDEX_W  = 32;
   localparam int LINE_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   typedef enum logic [1:0] {
      KIND_LITERAL = 2'd0,
      KIND_RUN     = 2'd1,
      KIND_EOL     = 2'd2,
      KIND_EOI     = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [WORD_W-1:0]    pixel_value;
      logic [RUN_W-1:0]     run_length;
      logic [INDEX_W-1:0]   start_index;
      logic [LINE_W-1:0]    line_number;
   } entry_type;

   typedef struct packed {
      logic push;
      logic full;
   } push_ctl_type;

endpackage

`default_nettype wire

>>> sv/srld_ifs.sv
// ----------------------------------------------------------------------------
// srld_ifs: channel interfaces of the sprite RLE line decoder
// Code word input channel and decoded result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface srld_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_word;

   modport source (output valid, output code_word, input ready);
   modport sink (input valid, input code_word, output ready);
endinterface

interface srld_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] pixel_value;
   logic [14:0] run_length;
   logic [31:0] start_index;
   logic [15:0] line_number;
   logic        overrun;

   modport source (output valid, output kind, output pixel_value, output run_length,
                   output start_index, output line_number, output overrun, input ready);
   modport sink (input valid, input kind, input pixel_value, input run_length,
                 input start_index, input line_number, input overrun, output ready);
endinterface

`default_nettype wire

>>> sv/sprite_rle_line_decoder_top.sv
// ----------------------------------------------------------------------------
// sprite_rle_line_decoder_top: sprite RLE line decoder
// Decodes 16-bit line-based run-length sprite words into literal pixels,
// transparent runs, end-of-line and end-of-image results.
//
//   Channel   Direction  Contents
//   req_chan  in         code_word
//   rsp_chan  out        kind, pixel_value, run_length, start_index,
//                        line_number, overrun
//   csr_*     in         write enable, register index, 16-bit write data
//
// One code word is accepted per cycle while the queue is not full; each result
// passes through a two-entry queue and then the output register. Reset is
// synchronous and clears the position, the queue and the configuration
// registers. A stalled result channel stalls the input only once the queue is
// full.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_rle_line_decoder_top
   import srld_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   srld_req_if.sink                   req_chan,
   srld_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [WORD_W-1:0]     csr_data
);

   logic [WORD_W-1:0] width_ff;
   logic [LINE_W-1:0] height_ff;
   push_ctl_type      ctl;
   entry_type         push_data, pop_data;
   logic              full, empty, pop, accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_chan.ready = !full;
   assign accept         = req_chan.valid && !full;

   srld_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept_i (accept),
      .word_i   (req_chan.code_word),
      .height_i (height_ff),
      .full_i   (full),
      .ctl_o    (ctl),
      .entry_o  (push_data)
   );

   srld_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .ctl_i       (ctl),
      .push_data_i (push_data),
      .pop_i       (pop),
      .full_o      (full),
      .empty_o     (empty),
      .pop_data_o  (pop_data)
   );

   srld_back u_back (
      .clock    (clock),
      .reset    (reset),
      .width_i  (width_ff),
      .height_i (height_ff),
      .empty_i  (empty),
      .entry_i  (pop_data),
      .pop_o    (pop),
      .rsp      (rsp_chan)
   );

endmodule

`default_nettype wire

>>> sv/srld_front.sv
// ----------------------------------------------------------------------------
// srld_front: code word classifier
// Accepts code words, tracks the literal count, line and pixel position, and
// pushes one result record per word that produces a result.
// ----------------------------------------------------------------------------
`default_nettype none

module srld_front
   import srld_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept_i,
   input  wire logic [WORD_W-1:0]   word_i,
   input  wire logic [LINE_W-1:0]   height_i,
   input  wire logic                full_i,
   output push_ctl_type             ctl_o,
   output entry_type               entry_o
);

   logic               phase_ff, phase_in;
   logic [RUN_W-1:0]   literals_left_ff, literals_left_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic [INDEX_W-1:0] pixel_ff, pixel_in;
   logic [RUN_W-1:0]   count;
   logic               push;

   assign count = word_i[WORD_W-1:1];

   always_comb begin
      phase_in             = phase_ff;
      literals_left_in     = literals_left_ff;
      line_in              = line_ff;
      pixel_in             = pixel_ff;
      push                 = 1'b0;
      entry_o.kind         = KIND_LITERAL;
      entry_o.pixel_value  = '0;
      entry_o.run_length   = '0;
      entry_o.start_index  = pixel_ff;
      entry_o.line_number  = line_ff;
      if (phase_ff) begin
         push                = 1'b1;
         entry_o.kind        = KIND_LITERAL;
         entry_o.pixel_value = word_i;
         entry_o.run_length  = RUN_W'(1);
         pixel_in            = pixel_ff + INDEX_W'(1);
         literals_left_in    = literals_left_ff - RUN_W'(1);
         phase_in            = (literals_left_in != '0);
      end else if (line_ff >= height_i) begin
         push         = 1'b1;
         entry_o.kind = KIND_EOI;
         line_in      = '0;
         pixel_in     = '0;
      end else if (word_i == '0) begin
         push         = 1'b1;
         entry_o.kind = KIND_EOL;
         line_in      = line_ff + LINE_W'(1);
      end else if (word_i[0]) begin
         literals_left_in = count;
         phase_in         = (count != '0);
      end else begin
         push               = 1'b1;
         entry_o.kind       = KIND_RUN;
         entry_o.run_length = count;
         pixel_in           = pixel_ff + INDEX_W'(count);
      end
   end

   assign ctl_o.push = accept_i && push;
   assign ctl_o.full = full_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= 1'b0;
         literals_left_ff <= '0;
         line_ff          <= '0;
         pixel_ff         <= '0;
      end else if (accept_i) begin
         phase_ff         <= phase_in;
         literals_left_ff <= literals_left_in;
         line_ff          <= line_in;
         pixel_ff         <= pixel_in;
      end
   end

`ifndef ASSERT_OFF
   a_phase_has_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> literals_left_ff != '0)
      else $error("literal phase entered with zero count");

   a_literal_tag_enters_phase: assert property (@(posedge clock) disable iff (reset)
      accept_i && !phase_ff && line_ff < height_i && word_i[0] && count != '0
      |=> phase_ff)
      else $error("literal tag did not start the literal phase");

   a_eoi_restarts_image: assert property (@(posedge clock) disable iff (reset)
      ctl_o.push && entry_o.kind == KIND_EOI |=> line_ff == '0 && pixel_ff == '0)
      else $error("end of image did not clear the position");
`endif

endmodule

`default_nettype wire

>>> sv/srld_queue.sv
// ----------------------------------------------------------------------------
// srld_queue: result record queue
// Short first-in first-out store that decouples the classifier from the
// output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module srld_queue
   import srld_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  push_ctl_type   ctl_i,
   input  entry_type      push_data_i,
   input  wire logic      pop_i,
   output logic           full_o,
   output logic           empty_o,
   output entry_type      pop_data_o
);

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full_o     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty_o    = (count_ff == '0);
   assign pop_data_o = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (ctl_i.push && !pop_i) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!ctl_i.push && pop_i) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_i.push) begin
         mem_ff[wr_ptr_ff] <= push_data_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (ctl_i.push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (pop_i) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      ctl_i.push |-> !ctl_i.full)
      else $error("push into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> !empty_o)
      else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

>>> sv/srld_back.sv
// ----------------------------------------------------------------------------
// srld_back: output stage
// Takes records from the queue, adds the overrun flag against the image area
// and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module srld_back
   import srld_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [WORD_W-1:0]  width_i,
   input  wire logic [LINE_W-1:0]  height_i,
   input  wire logic               empty_i,
   input  entry_type               entry_i,
   output logic                    pop_o,
   srld_rsp_if.source              rsp
);

   logic [INDEX_W-1:0] total_ff;
   logic [INDEX_W:0]   reach;
   logic               valid_ff;
   entry_type          data_ff;
   logic               overrun_ff, overrun_in;

   assign reach      = {1'b0, entry_i.start_index} + (INDEX_W + 1)'(entry_i.run_length);
   assign overrun_in = reach > {1'b0, total_ff};
   assign pop_o      = !empty_i && (!valid_ff || rsp.ready);

   always_ff @(posedge clock) begin
      total_ff <= INDEX_W'(width_i) * INDEX_W'(height_i);
      if (pop_o) begin
         data_ff    <= entry_i;
         overrun_ff <= overrun_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_o) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.kind        = data_ff.kind;
   assign rsp.pixel_value = data_ff.pixel_value;
   assign rsp.run_length  = data_ff.run_length;
   assign rsp.start_index = data_ff.start_index;
   assign rsp.line_number = data_ff.line_number;
   assign rsp.overrun     = overrun_ff;

endmodule

`default_nettype wire
